>>> sv/assert_macros.svh
// Assertion macros shared by the trie dictionary RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define TWIS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("trie assertion failed");

// Next-cycle implication, sampled on clock, off while reset is high.
`define TWIS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("trie assertion failed");

`endif

>>> sv/twis_pkg.sv
// Package: constants, beat types and controller types for the trie dictionary.
`timescale 1ns / 1ps
`default_nettype none
package twis_pkg;

   localparam int NODES    = 1024;
   localparam int ALPHABET = 26;
   localparam int SLOTS    = NODES * ALPHABET;
   localparam int NODE_W   = $clog2(NODES);
   localparam int CNT_W    = $clog2(NODES + 1);
   localparam int SLOT_W   = $clog2(SLOTS);
   localparam int LETTER_W = 5;

   localparam logic CMD_SEARCH  = 1'b0;
   localparam logic CMD_INSERT  = 1'b1;
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef struct packed {
      logic                cmd;
      logic [LETTER_W-1:0] letter;
      logic                last;
   } req_type;

   typedef struct packed {
      logic found;
      logic status;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_STEP,
      ST_MARK,
      ST_REPORT
   } state_type;

   typedef struct packed {
      logic clear;
      logic capture;
      logic step;
      logic mark;
      logic report;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic last;
   } ctrl_sts_type;

endpackage
`default_nettype wire

>>> sv/twis_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module twis_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

>>> sv/twis_ctrl.sv
// Controller state machine: clearing pass, letter step, end mark and report.
`timescale 1ns / 1ps
`default_nettype none
module twis_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   output twis_pkg::ctrl_cmd_type ctrl_cmd,
   input  twis_pkg::ctrl_sts_type ctrl_sts
);

   twis_pkg::state_type state_ff;
   twis_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= twis_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         twis_pkg::ST_CLEAR: begin
            if (ctrl_sts.clear_done) state_in = twis_pkg::ST_IDLE;
         end
         twis_pkg::ST_IDLE: begin
            if (start) state_in = twis_pkg::ST_STEP;
         end
         twis_pkg::ST_STEP: begin
            state_in = ctrl_sts.last ? twis_pkg::ST_MARK : twis_pkg::ST_IDLE;
         end
         twis_pkg::ST_MARK: begin
            state_in = twis_pkg::ST_REPORT;
         end
         twis_pkg::ST_REPORT: begin
            state_in = twis_pkg::ST_IDLE;
         end
         default: begin
            state_in = twis_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctrl_cmd = '0;
      busy     = 1'b1;
      case (state_ff)
         twis_pkg::ST_CLEAR:  ctrl_cmd.clear = 1'b1;
         twis_pkg::ST_IDLE: begin
            busy             = 1'b0;
            ctrl_cmd.capture = start;
         end
         twis_pkg::ST_STEP:   ctrl_cmd.step   = 1'b1;
         twis_pkg::ST_MARK:   ctrl_cmd.mark   = 1'b1;
         twis_pkg::ST_REPORT: ctrl_cmd.report = 1'b1;
         default:             busy = 1'b1;
      endcase
   end

endmodule
`default_nettype wire

>>> sv/twis_dpath.sv
// Datapath: child table, end-of-word flags, walk registers and clear counter.
`timescale 1ns / 1ps
`default_nettype none
module twis_dpath (
   input  logic                   clock,
   input  logic                   reset,
   input  twis_pkg::ctrl_cmd_type ctrl_cmd,
   output twis_pkg::ctrl_sts_type ctrl_sts,
   input  twis_pkg::req_type      req_data,
   output twis_pkg::rsp_type      rsp_data
);

   twis_pkg::req_type                item_ff;
   logic [twis_pkg::SLOT_W-1:0]      slot_ff;
   logic [twis_pkg::NODE_W-1:0]      cur_node_ff, cur_node_in;
   logic [twis_pkg::CNT_W-1:0]       next_free_ff, next_free_in;
   logic                             miss_ff, miss_in;
   logic                             full_ff, full_in;
   logic [twis_pkg::SLOT_W-1:0]      clr_cnt_ff;

   logic [twis_pkg::SLOT_W-1:0]      slot_now;
   logic                             child_we;
   logic [twis_pkg::SLOT_W-1:0]      child_addr;
   logic [twis_pkg::NODE_W-1:0]      child_wdata;
   logic [twis_pkg::NODE_W-1:0]      child_rdata;
   logic                             end_we;
   logic [twis_pkg::NODE_W-1:0]      end_addr;
   logic                             end_wdata;
   logic                             end_rdata;
   logic                             walk_ok;
   logic                             letter_bad;
   logic                             child_present;
   logic                             has_free;
   logic                             do_alloc;

   assign slot_now = twis_pkg::SLOT_W'(cur_node_ff) * twis_pkg::SLOT_W'(twis_pkg::ALPHABET)
                   + twis_pkg::SLOT_W'(req_data.letter);

   assign walk_ok       = !miss_ff && !full_ff;
   assign letter_bad    = int'(item_ff.letter) >= twis_pkg::ALPHABET;
   assign child_present = (child_rdata != '0)
                       && ({1'b0, child_rdata} < twis_pkg::CNT_W'(twis_pkg::NODES));
   assign has_free      = next_free_ff < twis_pkg::CNT_W'(twis_pkg::NODES);
   assign do_alloc      = ctrl_cmd.step && walk_ok && !letter_bad && !child_present
                       && (item_ff.cmd == twis_pkg::CMD_INSERT) && has_free;

   // child table port
   assign child_we    = ctrl_cmd.clear || do_alloc;
   assign child_addr  = ctrl_cmd.clear ? clr_cnt_ff : (ctrl_cmd.step ? slot_ff : slot_now);
   assign child_wdata = ctrl_cmd.clear ? '0 : next_free_ff[twis_pkg::NODE_W-1:0];

   // end-of-word flag port
   assign end_we    = (ctrl_cmd.clear && (clr_cnt_ff < twis_pkg::SLOT_W'(twis_pkg::NODES)))
                   || (ctrl_cmd.mark && walk_ok && (item_ff.cmd == twis_pkg::CMD_INSERT));
   assign end_addr  = ctrl_cmd.clear ? clr_cnt_ff[twis_pkg::NODE_W-1:0] : cur_node_ff;
   assign end_wdata = !ctrl_cmd.clear;

   twis_ram #(
      .WIDTH (twis_pkg::NODE_W),
      .DEPTH (twis_pkg::SLOTS)
   ) u_child_ram (
      .clock (clock),
      .we    (child_we),
      .addr  (child_addr),
      .wdata (child_wdata),
      .rdata (child_rdata)
   );

   twis_ram #(
      .WIDTH (1),
      .DEPTH (twis_pkg::NODES)
   ) u_end_ram (
      .clock (clock),
      .we    (end_we),
      .addr  (end_addr),
      .wdata (end_wdata),
      .rdata (end_rdata)
   );

   always_comb begin
      cur_node_in  = cur_node_ff;
      next_free_in = next_free_ff;
      miss_in      = miss_ff;
      full_in      = full_ff;
      if (ctrl_cmd.step && walk_ok) begin
         if (letter_bad) begin
            miss_in = 1'b1;
         end else if (child_present) begin
            cur_node_in = child_rdata;
         end else if (item_ff.cmd == twis_pkg::CMD_INSERT) begin
            if (has_free) begin
               cur_node_in  = next_free_ff[twis_pkg::NODE_W-1:0];
               next_free_in = next_free_ff + twis_pkg::CNT_W'(1);
            end else begin
               full_in = 1'b1;
            end
         end else begin
            miss_in = 1'b1;
         end
      end
      if (ctrl_cmd.report) begin
         cur_node_in = '0;
         miss_in     = 1'b0;
         full_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_node_ff  <= '0;
         next_free_ff <= twis_pkg::CNT_W'(1);
         miss_ff      <= 1'b0;
         full_ff      <= 1'b0;
         clr_cnt_ff   <= '0;
      end else begin
         cur_node_ff  <= cur_node_in;
         next_free_ff <= next_free_in;
         miss_ff      <= miss_in;
         full_ff      <= full_in;
         if (ctrl_cmd.clear) begin
            clr_cnt_ff <= clr_cnt_ff + twis_pkg::SLOT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl_cmd.capture) begin
         item_ff <= req_data;
         slot_ff <= slot_now;
      end
   end

   assign ctrl_sts.clear_done = clr_cnt_ff == twis_pkg::SLOT_W'(twis_pkg::SLOTS - 1);
   assign ctrl_sts.last       = item_ff.last;

   assign rsp_data.found  = (item_ff.cmd == twis_pkg::CMD_SEARCH) && walk_ok && end_rdata;
   assign rsp_data.status = full_ff ? twis_pkg::STATUS_FULL : twis_pkg::STATUS_OK;

endmodule
`default_nettype wire

>>> sv/trie_word_insert_search.sv
// Top level of the trie dictionary: controller, datapath and checks.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// Dictionary trie over a 26-letter alphabet, one letter per beat. A beat is
// taken when start is high and busy is low. A letter that is not last is
// handled as a child table read, then a walk decision; the last letter of a
// word goes on through step, end-flag access and report, and gives its result
// for exactly one cycle on rsp_valid. The receiver cannot stall: sample
// rsp_data whenever rsp_valid is high. After reset the block keeps busy high
// for a clearing pass over the child table and end flags.
module trie_word_insert_search (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  twis_pkg::req_type req_data,
   output logic              rsp_valid,
   output twis_pkg::rsp_type rsp_data
);

   twis_pkg::ctrl_cmd_type ctrl_cmd;
   twis_pkg::ctrl_sts_type ctrl_sts;

   twis_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .ctrl_cmd (ctrl_cmd),
      .ctrl_sts (ctrl_sts)
   );

   twis_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .ctrl_cmd (ctrl_cmd),
      .ctrl_sts (ctrl_sts),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

   assign rsp_valid = ctrl_cmd.report;

   `TWIS_ASSERT_NOW(a_rsp_while_busy, rsp_valid, busy)
   `TWIS_ASSERT_NEXT(a_rsp_single, rsp_valid, !rsp_valid)
   `TWIS_ASSERT_NEXT(a_accept_then_busy, start && !busy, busy && !rsp_valid)
   `TWIS_ASSERT_NOW(a_found_not_full, rsp_valid && rsp_data.found, !rsp_data.status)

endmodule
`default_nettype wire
